// ===== hw/rtl/lvu_pkg.sv =====
// Shared types and constants for the Langevin velocity update block.
// Used by every module under hw/rtl; depends on nothing.
package lvu_pkg;

  localparam int DECAY_W    = 17;
  localparam int SCALE_W    = 32;
  localparam int MASS_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int NUM_SHIFT  = 32;
  localparam int NUM_W      = 50;
  localparam int ROOT_W     = NUM_W / 2;
  localparam int K_W        = SCALE_W + ROOT_W - FRAC_W;

  localparam logic [DECAY_W-1:0] DECAY_ONE   = DECAY_W'(65536);
  localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_ONE;
  localparam logic [SCALE_W-1:0] SCALE_RESET = '0;

  localparam int VEL_WIDTH_DEF   = 32;
  localparam int NOISE_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY = 1'b0,
    CFG_SCALE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic zero_mass;
  } lvu_ctl_t;

endpackage

// ===== hw/rtl/langevin_velocity_update.sv =====
// Langevin thermostat velocity update, one particle per beat.
// Push a particle (velocity, mass, three noise samples) on the in_ side;
// pop v' = c1*v + c2*sqrt((1+c1)/mass)*noise, saturated, from the out_ side.
// Write c1 (index 0) and c2 (index 1) on cfg_ only while the block is idle.
// Reset (rst_n low, synchronous) empties the queue and pipeline and sets
// c1 to 1.0 and c2 to 0.
// Throughput: one particle per cycle while out_pop keeps up.
// Pipeline from push to out_empty falling: the input queue, 50 divider
// stages (one quotient bit per stage), 25 square root stages (one root
// bit per stage) and 3 multiply, round and output stages.
// When the receiver stalls, the whole back end holds; the 4-entry input
// queue keeps taking beats until it fills and raises in_full.
// A zero mass drops the noise term and sets out_mass_error.
// Depends on lvu_pkg, lvu_front, lvu_root and lvu_back.
module langevin_velocity_update #(
  parameter int VEL_WIDTH   = lvu_pkg::VEL_WIDTH_DEF,
  parameter int NOISE_WIDTH = lvu_pkg::NOISE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lvu_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lvu_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [VEL_WIDTH-1:0]           in_vel_x,
  input  logic [VEL_WIDTH-1:0]           in_vel_y,
  input  logic [VEL_WIDTH-1:0]           in_vel_z,
  input  logic [lvu_pkg::MASS_W-1:0]     in_particle_mass,
  input  logic [NOISE_WIDTH-1:0]         in_noise_x,
  input  logic [NOISE_WIDTH-1:0]         in_noise_y,
  input  logic [NOISE_WIDTH-1:0]         in_noise_z,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [VEL_WIDTH-1:0]           out_new_vel_x,
  output logic [VEL_WIDTH-1:0]           out_new_vel_y,
  output logic [VEL_WIDTH-1:0]           out_new_vel_z,
  output logic                           out_mass_error
);

  localparam int SIDE_W = 3 * (VEL_WIDTH + NOISE_WIDTH);

  logic [lvu_pkg::DECAY_W-1:0] decay_r, decay_nxt;
  logic [lvu_pkg::SCALE_W-1:0] scale_r, scale_nxt;

  logic [SIDE_W-1:0]          side_in, q_side, r_side;
  logic [lvu_pkg::MASS_W-1:0] q_mass;
  logic                       q_zero, q_empty, adv;
  logic [lvu_pkg::ROOT_W-1:0] root;
  logic [3*VEL_WIDTH-1:0]     vel_out;
  lvu_pkg::lvu_ctl_t          q_ctl, r_ctl;

  always_comb begin
    decay_nxt = decay_r;
    scale_nxt = scale_r;
    if (cfg_we) begin
      unique case (lvu_pkg::cfg_reg_t'(cfg_idx))
        lvu_pkg::CFG_DECAY: decay_nxt = cfg_wdata[lvu_pkg::DECAY_W-1:0];
        lvu_pkg::CFG_SCALE: scale_nxt = cfg_wdata[lvu_pkg::SCALE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= lvu_pkg::DECAY_RESET;
      scale_r <= lvu_pkg::SCALE_RESET;
    end else begin
      decay_r <= decay_nxt;
      scale_r <= scale_nxt;
    end
  end

  assign side_in = {in_noise_z, in_noise_y, in_noise_x, in_vel_z, in_vel_y, in_vel_x};

  lvu_front #(.W(SIDE_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .full      (in_full),
    .din       (side_in),
    .din_mass  (in_particle_mass),
    .pop       (adv),
    .empty     (q_empty),
    .dout      (q_side),
    .dout_mass (q_mass),
    .dout_zero (q_zero)
  );

  assign q_ctl.valid     = !q_empty;
  assign q_ctl.zero_mass = q_zero;

  lvu_root #(.SIDE_W(SIDE_W)) u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_ctl   (q_ctl),
    .decay    (decay_r),
    .mass     (q_mass),
    .side_in  (q_side),
    .out_ctl  (r_ctl),
    .root     (root),
    .side_out (r_side)
  );

  lvu_back #(
    .VEL_WIDTH   (VEL_WIDTH),
    .NOISE_WIDTH (NOISE_WIDTH),
    .SIDE_W      (SIDE_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (out_pop),
    .adv      (adv),
    .empty    (out_empty),
    .in_ctl   (r_ctl),
    .root     (root),
    .side     (r_side),
    .decay    (decay_r),
    .scale    (scale_r),
    .vel_out  (vel_out),
    .mass_err (out_mass_error)
  );

  assign out_new_vel_x = vel_out[0 +: VEL_WIDTH];
  assign out_new_vel_y = vel_out[VEL_WIDTH +: VEL_WIDTH];
  assign out_new_vel_z = vel_out[2*VEL_WIDTH +: VEL_WIDTH];

endmodule

// ===== hw/rtl/lvu_front.sv =====
// Front end: input queue that takes particle beats and tags zero mass.
// Depends on lvu_pkg.
module lvu_front #(
  parameter int W = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [W-1:0]               din,
  input  logic [lvu_pkg::MASS_W-1:0] din_mass,
  input  logic                       pop,
  output logic                       empty,
  output logic [W-1:0]               dout,
  output logic [lvu_pkg::MASS_W-1:0] dout_mass,
  output logic                       dout_zero
);

  localparam int DEPTH = lvu_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int E_W   = W + lvu_pkg::MASS_W + 1;

  logic [E_W-1:0]   mem [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;
  logic             wr_en, rd_en;
  logic [E_W-1:0]   head;

  assign full  = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;

  always_comb begin
    wr_nxt  = wr_en ? PTR_W'((wr_r + 1'b1) % DEPTH) : wr_r;
    rd_nxt  = rd_en ? PTR_W'((rd_r + 1'b1) % DEPTH) : rd_r;
    cnt_nxt = cnt_r + (PTR_W+1)'(wr_en) - (PTR_W+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_r] <= {(din_mass == '0), din_mass, din};
    end
  end

  assign head      = mem[rd_r];
  assign dout      = head[W-1:0];
  assign dout_mass = head[W +: lvu_pkg::MASS_W];
  assign dout_zero = head[E_W-1];

endmodule

// ===== hw/rtl/lvu_root.sv =====
// Back end, first part: one-bit-per-stage divide of (1+c1)<<32 by mass,
// then two-bits-per-stage integer square root. Depends on lvu_pkg.
module lvu_root #(
  parameter int SIDE_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  lvu_pkg::lvu_ctl_t           in_ctl,
  input  logic [lvu_pkg::DECAY_W-1:0] decay,
  input  logic [lvu_pkg::MASS_W-1:0]  mass,
  input  logic [SIDE_W-1:0]           side_in,
  output lvu_pkg::lvu_ctl_t           out_ctl,
  output logic [lvu_pkg::ROOT_W-1:0]  root,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int NUM_W  = lvu_pkg::NUM_W;
  localparam int MASS_W = lvu_pkg::MASS_W;
  localparam int ROOT_W = lvu_pkg::ROOT_W;
  localparam int SREM_W = ROOT_W + 2;

  logic [NUM_W-1:0]  dnum_r  [NUM_W+1];
  logic [MASS_W-1:0] drem_r  [NUM_W+1];
  logic [NUM_W-1:0]  dq_r    [NUM_W+1];
  logic [MASS_W-1:0] dmass_r [NUM_W+1];
  logic [SIDE_W-1:0] dside_r [NUM_W+1];
  lvu_pkg::lvu_ctl_t dctl_r  [NUM_W+1];

  logic [NUM_W-1:0]  sx_r    [ROOT_W];
  logic [SREM_W-1:0] srem_r  [ROOT_W];
  logic [ROOT_W-1:0] sroot_r [ROOT_W];
  logic [SIDE_W-1:0] sside_r [ROOT_W];
  lvu_pkg::lvu_ctl_t sctl_r  [ROOT_W];

  logic [NUM_W-1:0] num_in;

  assign num_in = (NUM_W'(lvu_pkg::DECAY_ONE) + NUM_W'(decay)) << lvu_pkg::NUM_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dctl_r[0] <= '0;
    end else if (adv) begin
      dctl_r[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dnum_r[0]  <= num_in;
      drem_r[0]  <= '0;
      dq_r[0]    <= '0;
      dmass_r[0] <= mass;
      dside_r[0] <= side_in;
    end
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    logic [MASS_W:0]   rem_sh;
    logic              ge;
    logic [MASS_W-1:0] rem_n;

    assign rem_sh = {drem_r[i], dnum_r[i][NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, dmass_r[i]});
    assign rem_n  = ge ? MASS_W'(rem_sh - {1'b0, dmass_r[i]}) : rem_sh[MASS_W-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dctl_r[i+1] <= '0;
      end else if (adv) begin
        dctl_r[i+1] <= dctl_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dnum_r[i+1]  <= dnum_r[i] << 1;
        drem_r[i+1]  <= rem_n;
        dq_r[i+1]    <= {dq_r[i][NUM_W-2:0], ge};
        dmass_r[i+1] <= dmass_r[i];
        dside_r[i+1] <= dside_r[i];
      end
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [NUM_W-1:0]  x_src;
    logic [SREM_W-1:0] rem_src;
    logic [ROOT_W-1:0] root_src;
    logic [SIDE_W-1:0] side_src;
    lvu_pkg::lvu_ctl_t ctl_src;
    logic [SREM_W+1:0] rem_sh;
    logic [SREM_W+1:0] trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign x_src    = dq_r[NUM_W];
      assign rem_src  = '0;
      assign root_src = '0;
      assign side_src = dside_r[NUM_W];
      assign ctl_src  = dctl_r[NUM_W];
    end else begin : g_next
      assign x_src    = sx_r[j-1];
      assign rem_src  = srem_r[j-1];
      assign root_src = sroot_r[j-1];
      assign side_src = sside_r[j-1];
      assign ctl_src  = sctl_r[j-1];
    end

    assign rem_sh = {rem_src, x_src[NUM_W-1 -: 2]};
    assign trial  = {(SREM_W+2-ROOT_W-2)'(0), root_src, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sctl_r[j] <= '0;
      end else if (adv) begin
        sctl_r[j] <= ctl_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sx_r[j]    <= x_src << 2;
        srem_r[j]  <= ge ? SREM_W'(rem_sh - trial) : SREM_W'(rem_sh);
        sroot_r[j] <= {root_src[ROOT_W-2:0], ge};
        sside_r[j] <= side_src;
      end
    end
  end

  assign out_ctl  = sctl_r[ROOT_W-1];
  assign root     = sroot_r[ROOT_W-1];
  assign side_out = sside_r[ROOT_W-1];

endmodule

// ===== hw/rtl/lvu_back.sv =====
// Back end, second part: thermal kick scale, decay and kick products,
// round, saturate and output register. Depends on lvu_pkg.
module lvu_back #(
  parameter int VEL_WIDTH   = lvu_pkg::VEL_WIDTH_DEF,
  parameter int NOISE_WIDTH = lvu_pkg::NOISE_WIDTH_DEF,
  parameter int SIDE_W      = 3 * (VEL_WIDTH + NOISE_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop,
  output logic                        adv,
  output logic                        empty,
  input  lvu_pkg::lvu_ctl_t           in_ctl,
  input  logic [lvu_pkg::ROOT_W-1:0]  root,
  input  logic [SIDE_W-1:0]           side,
  input  logic [lvu_pkg::DECAY_W-1:0] decay,
  input  logic [lvu_pkg::SCALE_W-1:0] scale,
  output logic [3*VEL_WIDTH-1:0]      vel_out,
  output logic                        mass_err
);

  localparam int K_W    = lvu_pkg::K_W;
  localparam int FRAC_W = lvu_pkg::FRAC_W;
  localparam int KP_W   = lvu_pkg::SCALE_W + lvu_pkg::ROOT_W + 1;
  localparam int D_W    = VEL_WIDTH + lvu_pkg::DECAY_W + 1;
  localparam int TP_W   = K_W + 1 + NOISE_WIDTH;
  localparam int TS_W   = TP_W + 4;
  localparam int SUM_W  = ((D_W > TS_W) ? D_W : TS_W) + 1;
  localparam int R_W    = SUM_W - FRAC_W;
  localparam int NOFS   = 3 * VEL_WIDTH;

  lvu_pkg::lvu_ctl_t ctl1_r, ctl2_r;
  logic              valid_r, err_r;
  logic [K_W-1:0]    k_r;
  logic [SIDE_W-1:0] side1_r;
  logic [KP_W-1:0]   kprod;
  logic signed [lvu_pkg::DECAY_W:0] dec_s;
  logic signed [K_W:0] k_s;
  logic signed [D_W-1:0]  d_r [3];
  logic signed [TS_W-1:0] t_r [3];
  logic [VEL_WIDTH-1:0]   v_r [3];

  assign adv   = !valid_r || pop;
  assign empty = !valid_r;
  assign mass_err = err_r;

  assign kprod = KP_W'(scale) * KP_W'(root) + KP_W'(1 << (FRAC_W - 1));
  assign dec_s = $signed({1'b0, decay});
  assign k_s   = $signed({1'b0, k_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r  <= '0;
      ctl2_r  <= '0;
      valid_r <= 1'b0;
    end else if (adv) begin
      ctl1_r  <= in_ctl;
      ctl2_r  <= ctl1_r;
      valid_r <= ctl2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r     <= in_ctl.zero_mass ? '0 : kprod[FRAC_W +: K_W];
      side1_r <= side;
      err_r   <= ctl2_r.zero_mass;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic signed [VEL_WIDTH-1:0]   v_s;
    logic signed [NOISE_WIDTH-1:0] n_s;
    logic signed [D_W-1:0]         d_c;
    logic signed [TP_W-1:0]        tp_c;
    logic signed [SUM_W-1:0]       sum;
    logic [R_W-1:0]                r;
    logic [R_W-VEL_WIDTH:0]        top;
    logic [VEL_WIDTH-1:0]          sat;

    assign v_s  = $signed(side1_r[c*VEL_WIDTH +: VEL_WIDTH]);
    assign n_s  = $signed(side1_r[NOFS + c*NOISE_WIDTH +: NOISE_WIDTH]);
    assign d_c  = dec_s * v_s;
    assign tp_c = k_s * n_s;

    assign sum = SUM_W'(d_r[c]) + SUM_W'(t_r[c]) + SUM_W'(1 << (FRAC_W - 1));
    assign r   = sum[SUM_W-1:FRAC_W];
    assign top = r[R_W-1:VEL_WIDTH-1];

    always_comb begin
      priority if (top == '0 || top == '1) begin
        sat = r[VEL_WIDTH-1:0];
      end else if (r[R_W-1]) begin
        sat = {1'b1, {(VEL_WIDTH-1){1'b0}}};
      end else begin
        sat = {1'b0, {(VEL_WIDTH-1){1'b1}}};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d_r[c] <= d_c;
        t_r[c] <= TS_W'(tp_c) <<< 4;
        v_r[c] <= sat;
      end
    end

    assign vel_out[c*VEL_WIDTH +: VEL_WIDTH] = v_r[c];
  end

endmodule
